@@ rtl/core/srng_pkg.sv @@
// Shared constants and types for the shuffled minimal-standard generator.
package srng_pkg;

    localparam int VAL_W = 31;
    localparam int MUL_W = 15;
    localparam int PROD_W = VAL_W + MUL_W;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int WARM_EXTRA = 8;

    localparam logic [MUL_W-1:0] LCG_MUL = 15'd16807;
    localparam logic [VAL_W-1:0] LCG_MOD = 31'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] OUT_MAX = 31'd2147483389;

    localparam logic CMD_DRAW = 1'b0;
    localparam logic CMD_RESEED = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_W_MUL,
        ST_W_RED,
        ST_D_MUL,
        ST_D_RED,
        ST_D_RD,
        ST_D_WR,
        ST_OUT
    } srng_state_t;

    typedef struct packed {
        logic             load;
        logic [VAL_W-1:0] seed;
        logic             mul;
        logic             step;
    } lehmer_ctl_t;

    typedef struct packed {
        logic start;
        logic fin;
    } slot_ctl_t;

endpackage

@@ rtl/core/shuffled_minimal_standard_rng.sv @@
// A draw on a loaded table steps the Lehmer state and computes the slot (ST_D_MUL, ST_D_RED),
// reads the table (ST_D_RD), writes the new state and takes the old entry (ST_D_WR), and
// registers the clamped result in ST_OUT; new items are taken only in idle. A reseed, or the
// first draw after reset, first runs a warm-up: each Lehmer step is a multiply and a reduce state.
// Reset clears the sequencer, Lehmer state (to 1), last output and loaded flag;
// the shuffle table is not cleared, it is always filled before it is read.
module shuffled_minimal_standard_rng #(
    parameter int TABLE_DEPTH = srng_pkg::TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] seed_value, [31] zero
    input  logic [0:0]  s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [30:0] rand_value, [31] zero
);
    import srng_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + WARM_EXTRA);

    srng_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [VAL_W-1:0] last_reg, last_next;
    logic             loaded_reg, loaded_next;
    logic             m_valid_reg, m_valid_next;
    logic [VAL_W-1:0] m_data_reg, m_data_next;

    lehmer_ctl_t      lctl;
    slot_ctl_t        sctl;
    logic [VAL_W-1:0] lehmer_state;
    logic [VAL_W-1:0] lehmer_red;
    logic [IDX_W-1:0] slot;
    logic             tbl_we;
    logic [IDX_W-1:0] tbl_waddr;
    logic [VAL_W-1:0] tbl_wdata;
    logic             tbl_re;
    logic [VAL_W-1:0] tbl_rdata;
    logic [VAL_W-1:0] seed_fixed;
    logic             accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept = s_tvalid && s_tready;

    // seed mod (2^31-1), zero taken as one
    assign seed_fixed = (s_tdata[VAL_W-1:0] == '0 || s_tdata[VAL_W-1:0] == LCG_MOD)
                        ? VAL_W'(1) : s_tdata[VAL_W-1:0];

    srng_lehmer u_lehmer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (lctl),
        .state     (lehmer_state),
        .red_value (lehmer_red)
    );

    srng_slot #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_slot (
        .aclk       (aclk),
        .ctl        (sctl),
        .last_value (last_reg),
        .slot       (slot)
    );

    // accesses are strictly sequenced by the FSM, so no two overlap on an entry
    srng_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_we),
        .wr_addr (tbl_waddr),
        .wr_data (tbl_wdata),
        .rd_en   (tbl_re),
        .rd_addr (slot),
        .rd_data (tbl_rdata)
    );

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        last_next = last_reg;
        loaded_next = loaded_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next = m_data_reg;
        lctl = '0;
        sctl = '0;
        tbl_we = 1'b0;
        tbl_waddr = cnt_reg[IDX_W-1:0];
        tbl_wdata = lehmer_red;
        tbl_re = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser[0] == CMD_RESEED || !loaded_reg) begin
                        lctl.load = 1'b1;
                        lctl.seed = (s_tuser[0] == CMD_RESEED) ? seed_fixed : VAL_W'(1);
                        cnt_next = CNT_W'(TABLE_DEPTH + WARM_EXTRA - 1);
                        state_next = ST_W_MUL;
                    end else begin
                        state_next = ST_D_MUL;
                    end
                end
            end
            ST_W_MUL: begin
                lctl.mul = 1'b1;
                state_next = ST_W_RED;
            end
            ST_W_RED: begin
                lctl.step = 1'b1;
                // last TABLE_DEPTH steps fill the table from the top slot down
                tbl_we = (cnt_reg < CNT_W'(TABLE_DEPTH));
                if (cnt_reg == '0) begin
                    last_next = lehmer_red;
                    loaded_next = 1'b1;
                    state_next = ST_D_MUL;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                    state_next = ST_W_MUL;
                end
            end
            ST_D_MUL: begin
                lctl.mul = 1'b1;
                sctl.start = 1'b1;
                state_next = ST_D_RED;
            end
            ST_D_RED: begin
                lctl.step = 1'b1;
                sctl.fin = 1'b1;
                state_next = ST_D_RD;
            end
            ST_D_RD: begin
                tbl_re = 1'b1;
                state_next = ST_D_WR;
            end
            ST_D_WR: begin
                tbl_we = 1'b1;
                tbl_waddr = slot;
                tbl_wdata = lehmer_state;
                last_next = tbl_rdata;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next = (last_reg > OUT_MAX) ? OUT_MAX : last_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            last_reg <= '0;
            loaded_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_reg <= last_next;
            loaded_reg <= loaded_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = {1'b0, m_data_reg};

    a_draw_skips_warmup: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && loaded_reg && s_tuser[0] == CMD_DRAW |=> state_reg == ST_D_MUL)
        else $error("draw on loaded table entered warm-up");

    a_table_loaded_on_write: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_D_WR |-> loaded_reg)
        else $error("table slot written before warm-up");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output state");

endmodule

@@ rtl/core/srng_lehmer.sv @@
// Lehmer state register with a registered 16807 multiply and Mersenne reduction.
module srng_lehmer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  srng_pkg::lehmer_ctl_t           ctl,
    output logic [srng_pkg::VAL_W-1:0]      state,
    output logic [srng_pkg::VAL_W-1:0]      red_value
);
    import srng_pkg::*;

    logic [VAL_W-1:0]  state_reg, state_next;
    logic [PROD_W-1:0] prod_reg;
    logic [VAL_W:0]    sum;
    logic [VAL_W:0]    sum_sub;

    // p mod (2^31-1) = low 31 bits + high bits, one conditional subtract
    always_comb begin
        sum = {1'b0, prod_reg[VAL_W-1:0]} + (VAL_W + 1)'(prod_reg[PROD_W-1:VAL_W]);
        sum_sub = sum - {1'b0, LCG_MOD};
        red_value = (sum >= {1'b0, LCG_MOD}) ? sum_sub[VAL_W-1:0] : sum[VAL_W-1:0];
    end

    always_comb begin
        state_next = state_reg;
        if (ctl.load) begin
            state_next = ctl.seed;
        end else if (ctl.step) begin
            state_next = red_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= VAL_W'(1);
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.mul) begin
            prod_reg <= PROD_W'(state_reg) * PROD_W'(LCG_MUL);
        end
    end

    assign state = state_reg;

    a_state_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != '0) else $error("lehmer state reached zero");

    a_state_below_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.step && !ctl.load |=> state_reg < LCG_MOD)
        else $error("lehmer state not reduced");

endmodule

@@ rtl/core/srng_slot.sv @@
// Slot index from the last output: divide by a constant via reciprocal plus one correction.
module srng_slot #(
    parameter int TABLE_DEPTH = srng_pkg::TABLE_DEPTH_DEF,
    parameter int IDX_W = $clog2(TABLE_DEPTH)
) (
    input  logic                            aclk,
    input  srng_pkg::slot_ctl_t             ctl,
    input  logic [srng_pkg::VAL_W-1:0]      last_value,
    output logic [IDX_W-1:0]                slot
);
    import srng_pkg::*;

    localparam logic [63:0] MOD64 = 64'd2147483647;
    localparam logic [VAL_W-1:0] SLOT_DIV =
        VAL_W'(64'd1 + (MOD64 - 64'd1) / 64'(TABLE_DEPTH));
    localparam logic [31:0] RECIP = 32'((64'd1 << VAL_W) / {33'd0, SLOT_DIV});
    localparam int QW = IDX_W + 1;
    localparam int PW = QW + 1 + VAL_W;

    logic [VAL_W+31:0] qprod_reg;
    logic [VAL_W-1:0]  x_reg;
    logic [IDX_W-1:0]  slot_reg;
    logic [QW-1:0]     q0;
    logic [QW:0]       qinc;
    logic [QW:0]       qc;
    logic [PW-1:0]     prod2;

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            qprod_reg <= (VAL_W + 32)'(last_value) * (VAL_W + 32)'(RECIP);
            x_reg <= last_value;
        end
    end

    // estimate is exact or one short; test the next multiple
    always_comb begin
        q0 = qprod_reg[VAL_W +: QW];
        qinc = {1'b0, q0} + (QW + 1)'(1);
        prod2 = PW'(qinc) * PW'(SLOT_DIV);
        qc = (PW'(x_reg) >= prod2) ? qinc : {1'b0, q0};
    end

    always_ff @(posedge aclk) begin
        if (ctl.fin) begin
            slot_reg <= (qc > (QW + 1)'(TABLE_DEPTH - 1)) ? IDX_W'(TABLE_DEPTH - 1)
                                                           : qc[IDX_W-1:0];
        end
    end

    assign slot = slot_reg;

    a_slot_in_range: assert property (@(posedge aclk)
        ctl.fin |=> slot_reg <= IDX_W'(TABLE_DEPTH - 1))
        else $error("slot index beyond table");

endmodule

@@ rtl/core/srng_table.sv @@
// Shuffle table: single-port-write, registered-read synchronous memory.
module srng_table #(
    parameter int TABLE_DEPTH = srng_pkg::TABLE_DEPTH_DEF,
    parameter int IDX_W = $clog2(TABLE_DEPTH)
) (
    input  logic                            aclk,
    input  logic                            wr_en,
    input  logic [IDX_W-1:0]                wr_addr,
    input  logic [srng_pkg::VAL_W-1:0]      wr_data,
    input  logic                            rd_en,
    input  logic [IDX_W-1:0]                rd_addr,
    output logic [srng_pkg::VAL_W-1:0]      rd_data
);
    import srng_pkg::*;

    logic [VAL_W-1:0] mem [TABLE_DEPTH];
    logic [VAL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ tb/sv/tb_shuffled_minimal_standard_rng.sv @@
// Self-checking testbench for the shuffled minimal-standard random generator.
module tb_shuffled_minimal_standard_rng;
    import srng_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam int unsigned SLOT_DIV = 1 + (int'(LCG_MOD) - 1) / DEPTH;
    localparam int RANDOM_ITEMS = 1820;
    localparam int SETTLE_CYCLES = 200;
    localparam int CYCLE_LIMIT = 500000;
    localparam logic [VAL_W-1:0] SEED_MAX = LCG_MOD - VAL_W'(1);

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [30:0] seed_value, [31] zero
    logic [0:0]  s_tuser;   // [0] cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [30:0] rand_value, [31] zero

    // predicted generator state
    logic [VAL_W-1:0] gen_state;
    logic [VAL_W-1:0] gen_last;
    logic [VAL_W-1:0] gen_table [DEPTH];
    bit               gen_loaded;

    logic [VAL_W-1:0] expected_values [$];
    int               error_count;
    int               cycle_count;
    bit               steady;

    shuffled_minimal_standard_rng #(
        .TABLE_DEPTH(DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [VAL_W-1:0] lehmer_next(input logic [VAL_W-1:0] s);
        longint unsigned prod;
        prod = longint'(s) * longint'(LCG_MUL);
        return VAL_W'(prod % longint'(LCG_MOD));
    endfunction

    function automatic void warm_table(input logic [VAL_W-1:0] seed);
        logic [VAL_W-1:0] s;
        s = seed % LCG_MOD;
        if (s == '0) begin
            s = VAL_W'(1);
        end
        for (int n = DEPTH + WARM_EXTRA - 1; n >= 0; n--) begin
            s = lehmer_next(s);
            if (n < DEPTH) begin
                gen_table[n] = s;
            end
        end
        gen_state = s;
        gen_last = gen_table[0];
        gen_loaded = 1'b1;
    endfunction

    function automatic logic [VAL_W-1:0] next_rand_value(input logic cmd,
                                                         input logic [VAL_W-1:0] seed);
        int unsigned slot;
        if (cmd == CMD_RESEED) begin
            warm_table(seed);
        end else if (!gen_loaded) begin
            warm_table(VAL_W'(1));
        end
        gen_state = lehmer_next(gen_state);
        slot = int'(gen_last) / SLOT_DIV;
        if (slot >= DEPTH) begin
            slot = DEPTH - 1;
        end
        gen_last = gen_table[slot];
        gen_table[slot] = gen_state;
        return (gen_last > OUT_MAX) ? OUT_MAX : gen_last;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what,
                 got, want);
        error_count++;
    endtask

    task automatic report_mismatch_if(input logic [31:0] got, input logic [31:0] want);
        if (got !== want) begin
            report_mismatch("rand_value", got, want);
        end
    endtask

    // result side: random back-pressure and comparison against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_values.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, 32'd0);
            end else begin
                report_mismatch_if(m_tdata, {1'b0, expected_values.pop_front()});
            end
        end
        m_tready <= steady || ($urandom_range(99) >= 28);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    // one transaction on the input side; s_tvalid stays high until the next call decides
    task automatic send_item(input logic cmd, input logic [VAL_W-1:0] seed);
        if (!steady && $urandom_range(99) < 28) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < 28) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, seed};
        s_tuser <= cmd;
        do @(posedge aclk); while (!s_tready);
        expected_values.push_back(next_rand_value(cmd, seed));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_values.size() != 0) @(posedge aclk);
    endtask

    task automatic test_draw_before_load();
        // the first draw straight after reset warms up from seed 1
        for (int i = 0; i < 4; i++) begin
            send_item(CMD_DRAW, VAL_W'($urandom));
        end
    endtask

    task automatic test_seed_extremes();
        logic [VAL_W-1:0] seeds [6];
        seeds = '{31'd0, 31'd1, SEED_MAX, LCG_MOD, 31'h2AAA_AAAA, 31'h5555_5555};
        foreach (seeds[i]) begin
            send_item(CMD_RESEED, seeds[i]);
            send_item(CMD_DRAW, ~seeds[i]);
            send_item(CMD_DRAW, seeds[i]);
        end
    endtask

    task automatic test_back_to_back_reseed();
        send_item(CMD_RESEED, 31'd12345);
        send_item(CMD_RESEED, 31'd12345);
        drain_results();
    endtask

    task automatic test_random_stream();
        logic             cmd;
        logic [VAL_W-1:0] seed;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // a long stretch with neither side idling
            steady = (i >= 700 && i < 1000);
            if (i == 400 || i == 1300) begin
                drain_results();
            end
            cmd = ($urandom_range(99) < 6) ? CMD_RESEED : CMD_DRAW;
            case ($urandom_range(15))
                0: seed = '0;
                1: seed = LCG_MOD;
                2: seed = SEED_MAX;
                default: seed = VAL_W'($urandom);
            endcase
            send_item(cmd, seed);
        end
        steady = 1'b0;
    endtask

    initial begin
        gen_state = VAL_W'(1);
        gen_last = '0;
        gen_loaded = 1'b0;
        error_count = 0;
        cycle_count = 0;
        steady = 1'b0;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= CMD_DRAW;
        m_tready <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_draw_before_load();
        test_seed_extremes();
        test_back_to_back_reseed();
        test_random_stream();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_values.size() != 0) begin
            report_mismatch("results never arrived", 32'(expected_values.size()), 32'd0);
        end
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/srng_pkg.sv
rtl/core/srng_lehmer.sv
rtl/core/srng_slot.sv
rtl/core/srng_table.sv
rtl/core/shuffled_minimal_standard_rng.sv
tb/sv/tb_shuffled_minimal_standard_rng.sv
